@@ hw/rtl/stv_pkg.sv @@
// Shared types, constants and arithmetic helpers of the simplex tableau solver.
// No dependencies; every other file in hw/rtl imports this package.
package stv_pkg;

   localparam int MAX_CONSTRAINTS = 8;
   localparam int MAX_VARIABLES   = 8;
   localparam int VALUE_BITS      = 32;
   localparam int NROWS           = MAX_CONSTRAINTS + 1;
   localparam int NCOLS           = MAX_VARIABLES + 1 + MAX_CONSTRAINTS;
   localparam int RHS_COL         = MAX_VARIABLES;
   localparam int SLACK0          = MAX_VARIABLES + 1;
   localparam int DEPTH           = NROWS * NCOLS;
   localparam int ADDR_BITS       = 8;
   localparam int FRAC_BITS       = 16;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [ADDR_BITS-1:0]         addr_type;

   localparam value_type FX_ONE    = 32'sh0001_0000;
   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] ST_LOADED    = 3'd0;
   localparam logic [2:0] ST_OPTIMAL   = 3'd1;
   localparam logic [2:0] ST_UNBOUNDED = 3'd2;
   localparam logic [2:0] ST_LIMIT     = 3'd3;
   localparam logic [2:0] ST_READ      = 3'd4;

   localparam logic [1:0] REG_CONSTRAINTS = 2'd0;
   localparam logic [1:0] REG_VARIABLES   = 2'd1;
   localparam logic [1:0] REG_PIVOT_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] row_index;
      logic [4:0] col_index;
      value_type  value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      value_type  result_value;
      logic [7:0] pivots_done;
   } rsp_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      value_type wr_data;
      addr_type  rd_addr;
   } mem_req_type;

   function automatic addr_type cell_addr(input logic [3:0] row, input logic [4:0] col);
      logic [8:0] a;
      a = 9'(row) * 9'(NCOLS) + 9'(col);
      return a[ADDR_BITS-1:0];
   endfunction

   function automatic logic [31:0] mag32(input value_type x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

   // Saturates an unsigned magnitude to the signed range and applies the sign.
   function automatic value_type sat_mag(input logic neg, input logic [47:0] q);
      logic [47:0] lim;
      logic [47:0] m;
      logic [31:0] r;
      lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
      m   = (q > lim) ? lim : q;
      r   = m[31:0];
      return neg ? (~r + 32'd1) : r;
   endfunction

   function automatic logic col_used(input logic [4:0] j, input logic [3:0] m,
                                     input logic [3:0] n);
      return (j < 5'(n)) || (j == 5'(RHS_COL)) ||
             ((j >= 5'(SLACK0)) && (j < 5'(SLACK0) + 5'(m)));
   endfunction

endpackage

@@ hw/rtl/stv_mem.sv @@
// Tableau store: one write port, one registered read port, and valid bits
// so that entries never written read as zero. Depends on stv_pkg.
module stv_mem (
   input  logic                clock,
   input  logic                reset,
   input  stv_pkg::mem_req_type mem_req,
   output stv_pkg::value_type  rd_data
);
   import stv_pkg::*;

   value_type        mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   value_type        rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= valid_ff[mem_req.rd_addr] ? mem[mem_req.rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/stv_div.sv @@
// Iterative fixed-point divider: (num * 2^16) / den, truncated, saturated.
// One quotient bit per cycle. Depends on stv_pkg.
module stv_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  stv_pkg::value_type num,
   input  stv_pkg::value_type den,
   output logic               done,
   output stv_pkg::value_type quo
);
   import stv_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] sh_ff, sh_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      trial   = {rem_ff[31:0], sh_ff[47]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = {mag32(num), 16'd0};
         rem_in  = '0;
         d_in    = mag32(den);
         neg_in  = num[31] ^ den[31];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            sh_in  = {sh_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            sh_in  = {sh_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   assign quo  = zero_ff ? '0 : sat_mag(neg_ff, sh_ff);

endmodule

@@ hw/rtl/simplex_tableau_solver_top.sv @@
// Top level of the simplex tableau solver: command port, register port,
// sequencer. Depends on stv_pkg, stv_mem and stv_div.
//
// Usage. An item is transferred on a rising edge with start high and busy
// low; each item gives exactly one result on rsp_data, marked by rsp_strobe
// for a single cycle. The receiver cannot stall: a result must be taken in
// the cycle it is shown.
// A load (opcode 0) writes one tableau cell, if its index lies inside the
// tableau, and answers in the next cycle; busy stays low, so loads can be
// transferred every cycle. A read (opcode 2) answers after the S_RDWAIT state,
// with busy high for one cycle, because the tableau memory has a registered
// read port. A solve (opcode 1) holds busy high until its result is shown.
// It first writes the slack columns, and then per pivot searches the used
// columns, runs the ratio test with one division per constraint row that
// has a positive pivot-column entry, scales the pivot row by dividing each
// used cell by the pivot, and updates each used cell of every other row
// with a nonzero pivot-column entry. The serial divider and the single
// memory port set the pace of these steps.
// The user must write registers through csr_wr_en, csr_index and csr_wdata only
// while the block is idle, not enforced by the block. Reset restores the register
// defaults, clears the pivot count and makes every cell read as zero at once.
module simplex_tableau_solver_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stv_pkg::req_type req_data,
   output logic             rsp_strobe,
   output stv_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import stv_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RDWAIT, S_SLACK, S_COL_RD, S_COL_CHK, S_COL_DONE, S_OPT_WAIT,
      S_RAT_RD, S_RAT_E, S_RAT_R, S_RAT_DIV, S_RAT_DONE, S_P_WAIT,
      S_PR_RD, S_PR_DIV0, S_PR_DIVW, S_EL_RD, S_EL_F, S_EL_JRD, S_EL_X, S_EL_Y
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  cons_ff, cons_in, vars_ff, vars_in;
   logic [7:0]  limit_ff, limit_in;
   logic [3:0]  i_ff, i_in, br_ff, br_in;
   logic [4:0]  j_ff, j_in, bc_ff, bc_in;
   value_type   bv_ff, bv_in, bq_ff, bq_in, p_ff, p_in, f_ff, f_in, den_ff, den_in;
   logic        found_ff, found_in, brfound_ff, brfound_in, rdin_ff, rdin_in;
   logic [7:0]  cnt_ff, cnt_in, pcount_ff, pcount_in;
   logic [63:0] prod_ff, prod_in;
   logic        psign_ff, psign_in;
   rsp_type     rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   mem_req_type mem_req;
   value_type   rd_data;
   logic        div_start, div_done;
   value_type   div_num, div_den, div_quo;

   logic [3:0]  m_use, n_use;
   logic        req_inside;
   value_type   load_val, mul_res, sub_res;
   logic signed [32:0] diff;

   stv_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   stv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Register values outside 1..8 are used clamped.
   assign m_use = (cons_ff == 4'd0) ? 4'd1 :
                  (cons_ff > 4'(MAX_CONSTRAINTS)) ? 4'(MAX_CONSTRAINTS) : cons_ff;
   assign n_use = (vars_ff == 4'd0) ? 4'd1 :
                  (vars_ff > 4'(MAX_VARIABLES)) ? 4'(MAX_VARIABLES) : vars_ff;

   assign req_inside = (req_data.row_index < 4'(NROWS)) && (req_data.col_index < 5'(NCOLS));

   // Objective coefficients are stored negated, saturating the most negative value.
   assign load_val = ((req_data.row_index == 4'd0) && (req_data.col_index < 5'(MAX_VARIABLES)))
                   ? ((req_data.value == VALUE_MIN) ? VALUE_MAX : -req_data.value)
                   : req_data.value;

   // Elimination arithmetic: registered product, then shift, saturate, subtract.
   assign mul_res = sat_mag(psign_ff, prod_ff[63:16]);
   assign diff    = {rd_data[31], rd_data} - {mul_res[31], mul_res};
   assign sub_res = (diff[32] != diff[31]) ? (diff[32] ? VALUE_MIN : VALUE_MAX) : diff[31:0];

   always_comb begin
      state_in   = state_ff;
      cons_in    = cons_ff;
      vars_in    = vars_ff;
      limit_in   = limit_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      bc_in      = bc_ff;
      br_in      = br_ff;
      bv_in      = bv_ff;
      bq_in      = bq_ff;
      p_in       = p_ff;
      f_in       = f_ff;
      den_in     = den_ff;
      found_in   = found_ff;
      brfound_in = brfound_ff;
      rdin_in    = rdin_ff;
      cnt_in     = cnt_ff;
      pcount_in  = pcount_ff;
      prod_in    = prod_ff;
      psign_in   = psign_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      mem_req    = '0;
      div_start  = 1'b0;
      div_num    = rd_data;
      div_den    = p_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_CONSTRAINTS: cons_in  = csr_wdata[3:0];
            REG_VARIABLES:   vars_in  = csr_wdata[3:0];
            REG_PIVOT_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_data.opcode)
                  OP_LOAD: begin
                     strobe_in = 1'b1;
                     rsp_in    = '{status: ST_LOADED, result_value: '0,
                                   pivots_done: pcount_ff};
                     if (req_inside) begin
                        mem_req.wr_en       = 1'b1;
                        mem_req.wr_addr     = cell_addr(req_data.row_index,
                                                        req_data.col_index);
                        mem_req.wr_data     = load_val;
                        rsp_in.result_value = load_val;
                     end
                  end
                  OP_SOLVE: begin
                     state_in = S_SLACK;
                     i_in     = '0;
                     j_in     = '0;
                     cnt_in   = '0;
                  end
                  OP_READ: begin
                     mem_req.rd_addr = cell_addr(req_data.row_index, req_data.col_index);
                     rdin_in         = req_inside;
                     state_in        = S_RDWAIT;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     rsp_in    = '{status: ST_LOADED, result_value: '0,
                                   pivots_done: pcount_ff};
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            strobe_in = 1'b1;
            rsp_in    = '{status: ST_READ, result_value: rdin_ff ? rd_data : '0,
                          pivots_done: pcount_ff};
            state_in  = S_IDLE;
         end
         S_SLACK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cell_addr(i_ff, 5'(SLACK0) + j_ff);
            mem_req.wr_data = (5'(i_ff) == j_ff + 5'd1) ? FX_ONE : '0;
            if (j_ff == 5'(MAX_CONSTRAINTS - 1)) begin
               j_in = '0;
               if (i_ff == 4'(NROWS - 1)) begin
                  state_in = S_COL_RD;
                  found_in = 1'b0;
                  bv_in    = '0;
               end else begin
                  i_in = i_ff + 4'd1;
               end
            end else begin
               j_in = j_ff + 5'd1;
            end
         end
         S_COL_RD: begin
            if (j_ff == 5'(NCOLS)) begin
               state_in = S_COL_DONE;
            end else if ((j_ff == 5'(RHS_COL)) || !col_used(j_ff, m_use, n_use)) begin
               j_in = j_ff + 5'd1;
            end else begin
               mem_req.rd_addr = cell_addr(4'd0, j_ff);
               state_in        = S_COL_CHK;
            end
         end
         S_COL_CHK: begin
            if (rd_data < bv_ff) begin
               bv_in    = rd_data;
               bc_in    = j_ff;
               found_in = 1'b1;
            end
            j_in     = j_ff + 5'd1;
            state_in = S_COL_RD;
         end
         S_COL_DONE: begin
            if (!found_ff) begin
               mem_req.rd_addr = cell_addr(4'd0, 5'(RHS_COL));
               state_in        = S_OPT_WAIT;
            end else if (cnt_ff >= limit_ff) begin
               strobe_in = 1'b1;
               rsp_in    = '{status: ST_LIMIT, result_value: '0, pivots_done: cnt_ff};
               pcount_in = cnt_ff;
               state_in  = S_IDLE;
            end else begin
               i_in       = 4'd1;
               brfound_in = 1'b0;
               state_in   = S_RAT_RD;
            end
         end
         S_OPT_WAIT: begin
            strobe_in = 1'b1;
            rsp_in    = '{status: ST_OPTIMAL, result_value: rd_data, pivots_done: cnt_ff};
            pcount_in = cnt_ff;
            state_in  = S_IDLE;
         end
         S_RAT_RD: begin
            if (i_ff > m_use) begin
               state_in = S_RAT_DONE;
            end else begin
               mem_req.rd_addr = cell_addr(i_ff, bc_ff);
               state_in        = S_RAT_E;
            end
         end
         S_RAT_E: begin
            if (rd_data > 0) begin
               den_in          = rd_data;
               mem_req.rd_addr = cell_addr(i_ff, 5'(RHS_COL));
               state_in        = S_RAT_R;
            end else begin
               i_in     = i_ff + 4'd1;
               state_in = S_RAT_RD;
            end
         end
         S_RAT_R: begin
            div_start = 1'b1;
            div_den   = den_ff;
            state_in  = S_RAT_DIV;
         end
         S_RAT_DIV: begin
            if (div_done) begin
               // Strict compare keeps the lowest row on ties.
               if (!brfound_ff || (div_quo < bq_ff)) begin
                  bq_in      = div_quo;
                  br_in      = i_ff;
                  brfound_in = 1'b1;
               end
               i_in     = i_ff + 4'd1;
               state_in = S_RAT_RD;
            end
         end
         S_RAT_DONE: begin
            if (!brfound_ff) begin
               strobe_in = 1'b1;
               rsp_in    = '{status: ST_UNBOUNDED, result_value: '0, pivots_done: cnt_ff};
               pcount_in = cnt_ff;
               state_in  = S_IDLE;
            end else begin
               mem_req.rd_addr = cell_addr(br_ff, bc_ff);
               state_in        = S_P_WAIT;
            end
         end
         S_P_WAIT: begin
            p_in     = rd_data;
            j_in     = '0;
            state_in = S_PR_RD;
         end
         S_PR_RD: begin
            if (j_ff == 5'(NCOLS)) begin
               i_in     = '0;
               state_in = S_EL_RD;
            end else if (!col_used(j_ff, m_use, n_use)) begin
               j_in = j_ff + 5'd1;
            end else begin
               mem_req.rd_addr = cell_addr(br_ff, j_ff);
               state_in        = S_PR_DIV0;
            end
         end
         S_PR_DIV0: begin
            div_start = 1'b1;
            state_in  = S_PR_DIVW;
         end
         S_PR_DIVW: begin
            if (div_done) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cell_addr(br_ff, j_ff);
               mem_req.wr_data = div_quo;
               j_in            = j_ff + 5'd1;
               state_in        = S_PR_RD;
            end
         end
         S_EL_RD: begin
            if (i_ff > m_use) begin
               cnt_in   = cnt_ff + 8'd1;
               j_in     = '0;
               found_in = 1'b0;
               bv_in    = '0;
               state_in = S_COL_RD;
            end else if (i_ff == br_ff) begin
               i_in = i_ff + 4'd1;
            end else begin
               mem_req.rd_addr = cell_addr(i_ff, bc_ff);
               state_in        = S_EL_F;
            end
         end
         S_EL_F: begin
            // The factor is captured before the row's own pivot column changes.
            f_in = rd_data;
            if (rd_data == '0) begin
               i_in     = i_ff + 4'd1;
               state_in = S_EL_RD;
            end else begin
               j_in     = '0;
               state_in = S_EL_JRD;
            end
         end
         S_EL_JRD: begin
            if (j_ff == 5'(NCOLS)) begin
               i_in     = i_ff + 4'd1;
               state_in = S_EL_RD;
            end else if (!col_used(j_ff, m_use, n_use)) begin
               j_in = j_ff + 5'd1;
            end else begin
               mem_req.rd_addr = cell_addr(br_ff, j_ff);
               state_in        = S_EL_X;
            end
         end
         S_EL_X: begin
            prod_in         = 64'(mag32(f_ff)) * 64'(mag32(rd_data));
            psign_in        = f_ff[31] ^ rd_data[31];
            mem_req.rd_addr = cell_addr(i_ff, j_ff);
            state_in        = S_EL_Y;
         end
         S_EL_Y: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cell_addr(i_ff, j_ff);
            mem_req.wr_data = sub_res;
            j_in            = j_ff + 5'd1;
            state_in        = S_EL_JRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cons_ff   <= 4'(MAX_CONSTRAINTS);
         vars_ff   <= 4'(MAX_VARIABLES);
         limit_ff  <= 8'd64;
         pcount_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cons_ff   <= cons_in;
         vars_ff   <= vars_in;
         limit_ff  <= limit_in;
         pcount_ff <= pcount_in;
         strobe_ff <= strobe_in;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      bc_ff      <= bc_in;
      br_ff      <= br_in;
      bv_ff      <= bv_in;
      bq_ff      <= bq_in;
      p_ff       <= p_in;
      f_ff       <= f_in;
      den_ff     <= den_in;
      found_ff   <= found_in;
      brfound_ff <= brfound_in;
      rdin_ff    <= rdin_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      psign_ff   <= psign_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ verif/simplex_tableau_solver_top_tb.sv @@
// Self-checking testbench for the simplex tableau solver top level.
// Depends on stv_pkg and the RTL under hw/rtl; holds its own fixed-point model of the solver.
module simplex_tableau_solver_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stv_pkg::*;

   localparam int ROWS = MAX_CONSTRAINTS + 1;
   localparam int COLS = MAX_VARIABLES + 1 + MAX_CONSTRAINTS;
   localparam longint WIDE_MAX = 64'sd2147483647;
   localparam longint WIDE_MIN = -64'sd2147483648;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   simplex_tableau_solver_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the solver: the tableau, the pivot count of the last
   // solve and the three registers.
   longint     shadow_tableau [ROWS][COLS];
   logic [7:0] shadow_pivots;
   logic [3:0] shadow_constraints;
   logic [3:0] shadow_variables;
   logic [7:0] shadow_limit;

   rsp_type expected_results [$];
   int      error_count = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      solve_outcomes [4];
   int      burst_left = 0;

   function automatic longint saturate(input longint x);
      if (x > WIDE_MAX) return WIDE_MAX;
      if (x < WIDE_MIN) return WIDE_MIN;
      return x;
   endfunction

   // Q16.16 product, truncated toward zero before saturation.
   function automatic longint fixed_mul(input longint a, input longint b);
      longint p;
      longint mag;
      p   = a * b;
      mag = ((p < 0) ? -p : p) >>> 16;
      return saturate((p < 0) ? -mag : mag);
   endfunction

   // Q16.16 quotient, truncated toward zero; dividing by zero gives zero.
   function automatic longint fixed_div(input longint a, input longint b);
      longint q;
      if (b == 0) return 0;
      q = (((a < 0) ? -a : a) <<< 16) / ((b < 0) ? -b : b);
      return saturate(((a < 0) != (b < 0)) ? -q : q);
   endfunction

   function automatic int clamp_count(input logic [3:0] v, input int top);
      if (v < 1) return 1;
      return (v > top) ? top : int'(v);
   endfunction

   function automatic bit column_active(input int j, input int m, input int n);
      return j < n || j == RHS_COL || (j >= SLACK0 && j < SLACK0 + m);
   endfunction

   function automatic void pivot_on(input int pr, input int pc, input int m, input int n);
      longint p;
      longint f;
      p = shadow_tableau[pr][pc];
      for (int j = 0; j < COLS; j++)
         if (column_active(j, m, n))
            shadow_tableau[pr][j] = fixed_div(shadow_tableau[pr][j], p);
      for (int i = 0; i <= m; i++) begin
         f = shadow_tableau[i][pc];
         if (i != pr && f != 0) begin
            for (int j = 0; j < COLS; j++)
               if (column_active(j, m, n))
                  shadow_tableau[i][j] = saturate(shadow_tableau[i][j] -
                                                  fixed_mul(f, shadow_tableau[pr][j]));
         end
      end
   endfunction

   // Dantzig rule: most negative objective entry enters, minimum ratio leaves.
   function automatic void solve_tableau(output logic [2:0] st, output longint v);
      int m;
      int n;
      int count;
      int enter_col;
      int leave_row;
      longint best_entry;
      longint best_ratio;
      longint ratio;
      m = clamp_count(shadow_constraints, MAX_CONSTRAINTS);
      n = clamp_count(shadow_variables, MAX_VARIABLES);
      count = 0;
      for (int i = 0; i < ROWS; i++)
         for (int k = 0; k < MAX_CONSTRAINTS; k++)
            shadow_tableau[i][SLACK0 + k] = (i == k + 1) ? 64'sd65536 : 64'sd0;
      forever begin
         enter_col = -1;
         leave_row = -1;
         best_entry = 0;
         best_ratio = 0;
         for (int j = 0; j < COLS; j++)
            if (j != RHS_COL && column_active(j, m, n) &&
                shadow_tableau[0][j] < best_entry) begin
               best_entry = shadow_tableau[0][j];
               enter_col = j;
            end
         if (enter_col < 0) begin
            st = ST_OPTIMAL;
            v = shadow_tableau[0][RHS_COL];
            break;
         end
         if (count >= shadow_limit) begin
            st = ST_LIMIT;
            v = 0;
            break;
         end
         for (int i = 1; i <= m; i++)
            if (shadow_tableau[i][enter_col] > 0) begin
               ratio = fixed_div(shadow_tableau[i][RHS_COL], shadow_tableau[i][enter_col]);
               if (leave_row < 0 || ratio < best_ratio) begin
                  best_ratio = ratio;
                  leave_row = i;
               end
            end
         if (leave_row < 0) begin
            st = ST_UNBOUNDED;
            v = 0;
            break;
         end
         pivot_on(leave_row, enter_col, m, n);
         count++;
      end
      shadow_pivots = count[7:0];
   endfunction

   function automatic rsp_type predict_result(input req_type cmd);
      rsp_type r;
      longint  v;
      longint  stored;
      bit      in_range;
      logic [2:0] st;
      v = longint'(cmd.value);
      in_range = cmd.row_index < ROWS && cmd.col_index < COLS;
      st = ST_LOADED;
      stored = 0;
      case (cmd.opcode)
         OP_LOAD: begin
            if (in_range) begin
               stored = (cmd.row_index == 0 && cmd.col_index < MAX_VARIABLES) ?
                        saturate(-v) : v;
               shadow_tableau[cmd.row_index][cmd.col_index] = stored;
            end
         end
         OP_SOLVE: solve_tableau(st, stored);
         OP_READ: begin
            st = ST_READ;
            if (in_range) stored = shadow_tableau[cmd.row_index][cmd.col_index];
         end
         default: ;
      endcase
      if (cmd.opcode == OP_SOLVE) solve_outcomes[st]++;
      r.status = st;
      r.result_value = value_type'(saturate(stored));
      r.pivots_done = shadow_pivots;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Results are shown for one cycle and cannot be held off, so every strobe
   // is checked against the oldest outstanding expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", longint'(rsp_data.status),
                            longint'(-1));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", longint'(rsp_data.status), longint'(want.status));
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", longint'(rsp_data.result_value),
                               longint'(want.result_value));
            if (rsp_data.pivots_done !== want.pivots_done)
               report_mismatch("pivots_done", longint'(rsp_data.pivots_done),
                               longint'(want.pivots_done));
         end
      end
   end

   // Sends one command. The sender runs in bursts: within a burst the task
   // returns in the time step of its transfer; at the end of a burst it drops
   // start for a random gap and returns after it.
   task automatic issue_command(input req_type cmd);
      int gap;
      start <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(predict_result(cmd));
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(0, 8);
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [1:0] op, input logic [3:0] row,
                              input logic [4:0] col, input logic [31:0] value);
      req_type cmd;
      cmd.opcode = op;
      cmd.row_index = row;
      cmd.col_index = col;
      cmd.value = value;
      issue_command(cmd);
   endtask

   // Stops sending and waits until every outstanding result has arrived,
   // then lets the clock run on so the block is surely idle.
   task automatic wait_until_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         REG_CONSTRAINTS: shadow_constraints = data[3:0];
         REG_VARIABLES:   shadow_variables = data[3:0];
         REG_PIVOT_LIMIT: shadow_limit = data;
         default: ;
      endcase
   endtask

   task automatic set_shape(input logic [7:0] m, input logic [7:0] n, input logic [7:0] lim);
      wait_until_idle();
      write_register(REG_CONSTRAINTS, m);
      write_register(REG_VARIABLES, n);
      write_register(REG_PIVOT_LIMIT, lim);
   endtask

   // Mostly small Q16.16 numbers with an occasional fraction; now and then
   // a fully random word so every value bit toggles.
   function automatic logic [31:0] pick_value(input bit positive);
      int whole;
      if ($urandom_range(0, 19) == 0) return $urandom;
      whole = positive ? $urandom_range(1, 12) : $urandom_range(0, 14) - 6;
      return (whole <<< 16) + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0);
   endfunction

   task automatic test_reset_state();
      send_fields(OP_READ, 4'd0, 5'd0, 32'h0);
      send_fields(OP_READ, 4'd8, 5'd16, 32'h0);
      send_fields(OP_UNUSED, 4'd3, 5'd3, 32'hFFFF_FFFF);
   endtask

   // Extremes of every field, the negated objective load, out-of-range
   // indexes and the register clamping.
   task automatic test_directed();
      send_fields(OP_LOAD, 4'd0, 5'd0, VALUE_MIN);
      send_fields(OP_LOAD, 4'd0, 5'd7, VALUE_MAX);
      send_fields(OP_LOAD, 4'd0, 5'd8, VALUE_MIN);
      send_fields(OP_LOAD, 4'd8, 5'd16, VALUE_MAX);
      send_fields(OP_LOAD, 4'd9, 5'd0, 32'h0001_0000);
      send_fields(OP_LOAD, 4'd15, 5'd31, 32'hFFFF_FFFF);
      send_fields(OP_LOAD, 4'd1, 5'd17, 32'h0002_0000);
      send_fields(OP_READ, 4'd0, 5'd0, 32'h0);
      send_fields(OP_READ, 4'd0, 5'd7, 32'h0);
      send_fields(OP_READ, 4'd15, 5'd31, 32'h0);
      send_fields(OP_READ, 4'd9, 5'd4, 32'h0);
      // Zero-width registers clamp to one row and one column; a pivot limit
      // of zero stops at once when the objective still improves.
      set_shape(8'd0, 8'd0, 8'd0);
      send_fields(OP_LOAD, 4'd0, 5'd0, 32'h0003_0000);
      send_fields(OP_LOAD, 4'd1, 5'd0, 32'h0002_0000);
      send_fields(OP_LOAD, 4'd1, 5'd8, 32'h0004_0000);
      send_fields(OP_SOLVE, 4'd0, 5'd0, 32'h0);
      set_shape(8'hFF, 8'hFF, 8'd255);
      send_fields(OP_SOLVE, 4'd0, 5'd0, 32'h0);
      // Unbounded: an improving column with no positive constraint entry.
      set_shape(8'd1, 8'd1, 8'd64);
      send_fields(OP_LOAD, 4'd0, 5'd0, 32'h0001_0000);
      send_fields(OP_LOAD, 4'd1, 5'd0, 32'hFFFF_0000);
      send_fields(OP_SOLVE, 4'd0, 5'd0, 32'h0);
      send_fields(OP_READ, 4'd1, 5'd9, 32'h0);
   endtask

   // Well-formed problems with random content: load every used cell, solve,
   // read some of the result back, sometimes solve again. A share of noise
   // commands lands anywhere in the index space.
   task automatic test_random_problems(input int target);
      int m;
      int n;
      while (items_sent < target) begin
         if ($urandom_range(0, 7) == 0) begin
            m = $urandom_range(4, 8);
            n = $urandom_range(4, 8);
         end else begin
            m = $urandom_range(1, 3);
            n = $urandom_range(1, 3);
         end
         set_shape(8'(m), 8'(n),
                   8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(6, 16)));
         for (int i = 0; i <= m; i++) begin
            for (int j = 0; j < n; j++)
               send_fields(OP_LOAD, 4'(i), 5'(j), pick_value(i == 0 && $urandom_range(0, 3) != 0));
            send_fields(OP_LOAD, 4'(i), 5'(RHS_COL),
                        i == 0 ? 32'h0 : pick_value($urandom_range(0, 9) != 0));
         end
         repeat ($urandom_range(0, 3))
            send_fields(2'($urandom_range(0, 3)), 4'($urandom), 5'($urandom), $urandom);
         send_fields(OP_SOLVE, 4'($urandom), 5'($urandom), $urandom);
         repeat ($urandom_range(1, 4))
            send_fields(OP_READ, 4'($urandom_range(0, m)), 5'($urandom_range(0, COLS - 1)),
                        $urandom);
         if ($urandom_range(0, 4) == 0) send_fields(OP_SOLVE, 4'd0, 5'd0, 32'h0);
         if ($urandom_range(0, 5) == 0) send_fields(OP_READ, 4'($urandom), 5'($urandom), $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < ROWS; i++)
         for (int j = 0; j < COLS; j++)
            shadow_tableau[i][j] = 0;
      shadow_pivots = '0;
      shadow_constraints = 4'd8;
      shadow_variables = 4'd8;
      shadow_limit = 8'd64;
      solve_outcomes = '{default: 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed();
      test_random_problems(680);

      wait_until_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d transfers and %0d results.", items_sent, results_seen);
      $display("Solves: %0d optimal, %0d unbounded, %0d at pivot limit.",
               solve_outcomes[ST_OPTIMAL], solve_outcomes[ST_UNBOUNDED],
               solve_outcomes[ST_LIMIT]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("simplex_tableau_solver_top_tb passed");
      end else begin
         $display("simplex_tableau_solver_top_tb failed");
      end
      $finish;
   end

   // This bound leaves ample room for the whole run, solves on the largest
   // tableau at the highest pivot limit included.
   initial begin
      #(120ms);
      $display("Timeout with %0d results outstanding.", expected_results.size());
      $display("simplex_tableau_solver_top_tb failed");
      $finish;
   end

endmodule
